// File: rtl/ogn_pkg.sv
// shared constants, codes and sine table builder for the octave gradient noise block
package ogn_pkg;

  localparam int unsigned MaxOctaves = 8;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned AngleBits  = 10;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned NoiseW  = 16;
  localparam int unsigned SeedW   = 32;
  localparam int unsigned OctW    = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  // width of corner dot products and per-octave noise in q16
  localparam int unsigned DotW = 20;

  // pipeline depth: stages 0..11 inside each lane, then sum and output
  localparam int unsigned LaneStages = 12;
  localparam int unsigned Stages     = 14;

  localparam int QOne = 65536;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEED = 2'd0,
    CFG_OCT  = 2'd1
  } cfg_idx_e;

  localparam logic [63:0] TwoPiQ30 = 64'd6746518852;

  // quarter wave sine in q14, taylor series in q30, used only on constants
  function automatic logic [14:0] quarter_sin(input int unsigned k, input int unsigned ab);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    x    = (64'(k) * TwoPiQ30) >> ab;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    r = (64'(sum) + 64'd32768) >> 16;
    if (r > 64'd16384) begin
      r = 64'd16384;
    end
    return r[14:0];
  endfunction

endpackage

// File: rtl/octave_gradient_noise_2d.sv
// top level of the multi-octave 2d gradient noise pipeline
//
//   channel  signals                                  direction  content
//   config   cfg_we_i cfg_idx_i cfg_data_i            in         seed, octave count
//   input    in_valid_i in_ready_o                    in         x_coord_i, y_coord_i
//   output   out_valid_o out_ready_i                  out        noise_value_o
//
// one item per cycle sustained while out_ready_i holds
// pipeline depth is set by the hash chain: three dependent 32-bit multiplies, each registered,
// followed by the gradient table, two dot product stages, four blend stages, sum and output
// every octave has its own lane, so the octave count does not change the rate
// reset clears the valid bits and the config registers: seed 0, octave count 3
// a full stage holds while its successor does not load, so bubbles are squeezed out and an
// item is taken even while a finished result waits at the output
module octave_gradient_noise_2d #(
  parameter int unsigned MAX_OCTAVES = ogn_pkg::MaxOctaves,
  parameter int unsigned FRAC_BITS   = ogn_pkg::FracBits,
  parameter int unsigned ANGLE_BITS  = ogn_pkg::AngleBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ogn_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [ogn_pkg::CfgW-1:0]            cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [ogn_pkg::CoordW-1:0]   x_coord_i,
  input  logic signed [ogn_pkg::CoordW-1:0]   y_coord_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ogn_pkg::NoiseW-1:0]   noise_value_o
);

  localparam int unsigned DW    = ogn_pkg::DotW;
  localparam int unsigned SUM_W = DW + $clog2(MAX_OCTAVES) + 1;
  localparam int unsigned ST    = ogn_pkg::Stages;
  localparam int unsigned LS    = ogn_pkg::LaneStages;

  logic [ogn_pkg::SeedW-1:0]     seed_q;
  logic [ogn_pkg::OctW-1:0]      octave_count_q;
  logic [ST-1:0]                 en;
  logic [ST-1:0]                 vld;
  logic signed [DW-1:0]          lane_val [MAX_OCTAVES];
  logic signed [SUM_W-1:0]       sum_d;
  logic signed [SUM_W-1:0]       sum_q;
  logic signed [17:0]            sat;
  logic signed [17:0]            rnd;
  logic signed [ogn_pkg::NoiseW-1:0] noise_q;

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q         <= '0;
      octave_count_q <= ogn_pkg::OctW'(3);
    end else if (cfg_we_i) begin
      unique case (ogn_pkg::cfg_idx_e'(cfg_idx_i))
        ogn_pkg::CFG_SEED: seed_q         <= cfg_data_i;
        ogn_pkg::CFG_OCT:  octave_count_q <= cfg_data_i[ogn_pkg::OctW-1:0];
        default: ;
      endcase
    end
  end

  ogn_ctrl #(
    .STAGES (ST)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .en_o        (en),
    .vld_o       (vld)
  );

  // one lane per octave, lane i works on the point scaled by 2^i
  for (genvar l = 0; l < MAX_OCTAVES; l++) begin : g_lane
    ogn_lane #(
      .LANE       (l),
      .FRAC_BITS  (FRAC_BITS),
      .ANGLE_BITS (ANGLE_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .en_i      (en[LS-1:0]),
      .seed_i    (seed_q),
      .x_coord_i (x_coord_i),
      .y_coord_i (y_coord_i),
      .value_o   (lane_val[l])
    );
  end

  // octaves past the count add nothing; a count above the lane count uses all lanes
  always_comb begin
    sum_d = '0;
    for (int l = 0; l < MAX_OCTAVES; l++) begin
      if (5'(l) < {1'b0, octave_count_q}) begin
        sum_d = sum_d + SUM_W'(lane_val[l]);
      end
    end
  end

  // clamp to [-1, 1] in q16, then round to q14
  always_comb begin
    if (sum_q > SUM_W'(ogn_pkg::QOne)) begin
      sat = 18'(ogn_pkg::QOne);
    end else if (sum_q < -SUM_W'(ogn_pkg::QOne)) begin
      sat = -18'(ogn_pkg::QOne);
    end else begin
      sat = 18'(sum_q);
    end
    rnd = (sat + 18'sd2) >>> 2;
  end

  always_ff @(posedge clk_i) begin
    if (en[LS]) begin
      sum_q <= sum_d;
    end
    if (en[ST-1]) begin
      noise_q <= ogn_pkg::NoiseW'(rnd);
    end
  end

  assign in_ready_o    = en[0];
  assign out_valid_o   = vld[ST-1];
  assign noise_value_o = noise_q;

`ifndef SYNTHESIS
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (noise_value_o >= -16'sd16384) && (noise_value_o <= 16'sd16384))
    else $error("noise value outside [-1, 1]");
`endif

endmodule

// File: rtl/ogn_ctrl.sv
// valid bits and per-stage load enables of the noise pipeline
module ogn_ctrl #(
  parameter int unsigned STAGES = ogn_pkg::Stages
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  output logic [STAGES-1:0] en_o,
  output logic [STAGES-1:0] vld_o
);

  logic [STAGES-1:0] vld_q;
  logic [STAGES-1:0] vld_d;
  logic [STAGES-1:0] en;

  // a stage loads when it is empty or its successor loads
  always_comb begin
    en[STAGES-1] = ~vld_q[STAGES-1] | out_ready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  assign vld_d = (en & {vld_q[STAGES-2:0], in_valid_i}) | (~en & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign en_o  = en;
  assign vld_o = vld_q;

`ifndef SYNTHESIS
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && en[0]) && !(vld_q[STAGES-1] && out_ready_i)
    |=> $countones(vld_q) == $past($countones(vld_q)) + 1)
    else $error("item count did not rise on accept");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && en[0]) && (vld_q[STAGES-1] && out_ready_i)
    |=> $countones(vld_q) == $past($countones(vld_q)) - 1)
    else $error("item count did not fall on delivery");
  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && en[0]) == (vld_q[STAGES-1] && out_ready_i)
    |=> $countones(vld_q) == $past($countones(vld_q)))
    else $error("item lost or duplicated in pipeline");
`endif

endmodule

// File: rtl/ogn_hash.sv
// lattice hash and gradient lookup, five register stages
module ogn_hash #(
  parameter int unsigned ANGLE_BITS = ogn_pkg::AngleBits
) (
  input  logic               clk_i,
  input  logic [4:0]         en_i,
  input  logic [31:0]        seed_i,
  input  logic [31:0]        cx_i,
  input  logic [31:0]        cy_i,
  output logic signed [15:0] gx_o,
  output logic signed [15:0] gy_o
);

  localparam int unsigned QN = 1 << (ANGLE_BITS - 2);
  localparam int unsigned AW = ANGLE_BITS - 1;

  logic [31:0]           n0;
  logic [31:0]           n_q;
  logic [31:0]           n2_q;
  logic [31:0]           n3_q;
  logic [31:0]           sq_q;
  logic [31:0]           q_q;
  logic [30:0]           m_q;
  logic [30:0]           dif;
  logic [ANGLE_BITS-1:0] idx_y;
  logic [ANGLE_BITS-1:0] idx_x;
  logic [AW:0]           fy;
  logic [AW:0]           fx;
  logic [14:0]           mag_y;
  logic [14:0]           mag_x;
  logic signed [15:0]    gx_q;
  logic signed [15:0]    gy_q;
  logic [14:0]           sin_tab [QN+1];

  for (genvar k = 0; k <= QN; k++) begin : g_tab
    assign sin_tab[k] = ogn_pkg::quarter_sin(k, ANGLE_BITS);
  end

  // {negate, table address} for a full-circle index
  function automatic logic [AW:0] fold(input logic [ANGLE_BITS-1:0] k);
    logic [AW-1:0] r;
    r             = k[ANGLE_BITS-3:0];
    fold[AW]      = k[ANGLE_BITS-1];
    fold[AW-1:0]  = k[ANGLE_BITS-2] ? AW'(QN) - AW'(r) : AW'(r);
  endfunction

  assign n0 = cx_i + cy_i * 32'd57 + seed_i;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      n_q <= (n0 << 13) ^ n0;
    end
    if (en_i[1]) begin
      sq_q <= n_q * n_q;
      n2_q <= n_q;
    end
    if (en_i[2]) begin
      q_q  <= sq_q * 32'd15731 + 32'd789221;
      n3_q <= n2_q;
    end
    if (en_i[3]) begin
      m_q <= 31'(n3_q * q_q + 32'd1376312589);
    end
    if (en_i[4]) begin
      gy_q <= fy[AW] ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
      gx_q <= fx[AW] ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
    end
  end

  // angle index, cosine is a quarter turn ahead
  assign dif   = 31'h4000_0000 - m_q;
  assign idx_y = dif[30 -: ANGLE_BITS];
  assign idx_x = idx_y + ANGLE_BITS'(QN);
  assign fy    = fold(idx_y);
  assign fx    = fold(idx_x);
  assign mag_y = sin_tab[fy[AW-1:0]];
  assign mag_x = sin_tab[fx[AW-1:0]];

  assign gx_o = gx_q;
  assign gy_o = gy_q;

endmodule

// File: rtl/ogn_fade.sv
// quintic fade curve in q16, four register stages
module ogn_fade (
  input  logic        clk_i,
  input  logic [3:0]  en_i,
  input  logic [15:0] t_i,
  output logic [16:0] s_o
);

  logic signed [21:0] a;
  logic [31:0]        tt_q;
  logic signed [38:0] ta_q;
  logic [15:0]        t1_q;
  logic [31:0]        t3p_q;
  logic [19:0]        b_q;
  logic [35:0]        sp_q;
  logic [16:0]        s_q;

  assign a = $signed({6'b0, t_i}) * 22'sd6 - 22'sd983040;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      tt_q <= 32'(t_i) * 32'(t_i);
      ta_q <= $signed({1'b0, t_i}) * a;
      t1_q <= t_i;
    end
    if (en_i[1]) begin
      t3p_q <= 32'(tt_q[31:16]) * 32'(t1_q);
      b_q   <= 20'((ta_q >>> 16) + 39'sd655360);
    end
    if (en_i[2]) begin
      sp_q <= 36'(t3p_q[31:16]) * 36'(b_q);
    end
    if (en_i[3]) begin
      s_q <= 17'(sp_q >> 16);
    end
  end

  assign s_o = s_q;

endmodule

// File: rtl/ogn_lane.sv
// one octave: scaling, four corner gradients, dot products, fade and blend
module ogn_lane #(
  parameter int unsigned LANE       = 0,
  parameter int unsigned FRAC_BITS  = ogn_pkg::FracBits,
  parameter int unsigned ANGLE_BITS = ogn_pkg::AngleBits
) (
  input  logic                              clk_i,
  input  logic [ogn_pkg::LaneStages-1:0]    en_i,
  input  logic [31:0]                       seed_i,
  input  logic signed [31:0]                x_coord_i,
  input  logic signed [31:0]                y_coord_i,
  output logic signed [ogn_pkg::DotW-1:0]   value_o
);

  localparam int unsigned DW  = ogn_pkg::DotW;
  localparam int unsigned DW1 = DW + 1;
  localparam int unsigned PW  = DW1 + 18;

  logic [63:0]           xs;
  logic [63:0]           ys;
  logic [FRAC_BITS+15:0] fxw;
  logic [FRAC_BITS+15:0] fyw;
  logic [31:0]           x0_q;
  logic [31:0]           y0_q;
  logic [31:0]           x1;
  logic [31:0]           y1;
  logic [15:0]           fx_q [0:5];
  logic [15:0]           fy_q [0:5];
  logic [16:0]           sx_f;
  logic [16:0]           sy_f;
  logic [16:0]           sx_q [5:7];
  logic [16:0]           sy_q [5:9];
  logic signed [DW-1:0]  dot_q [4];
  logic signed [DW1-1:0] dtop;
  logic signed [DW1-1:0] dbot;
  logic signed [PW-1:0]  mtop_q;
  logic signed [PW-1:0]  mbot_q;
  logic signed [DW-1:0]  tl_q;
  logic signed [DW-1:0]  bl_q;
  logic signed [DW-1:0]  top_q;
  logic signed [DW-1:0]  bot_q;
  logic signed [DW1-1:0] dy_mix;
  logic signed [PW-1:0]  my_q;
  logic signed [DW-1:0]  top10_q;
  logic signed [DW-1:0]  val;
  logic signed [DW-1:0]  value_q;

  // scale by 2^LANE, split into lattice cell and q16 fraction
  assign xs  = {{32{x_coord_i[31]}}, x_coord_i} << LANE;
  assign ys  = {{32{y_coord_i[31]}}, y_coord_i} << LANE;
  assign fxw = {xs[FRAC_BITS-1:0], 16'b0};
  assign fyw = {ys[FRAC_BITS-1:0], 16'b0};

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x0_q    <= xs[FRAC_BITS+31:FRAC_BITS];
      y0_q    <= ys[FRAC_BITS+31:FRAC_BITS];
      fx_q[0] <= fxw[FRAC_BITS+15:FRAC_BITS];
      fy_q[0] <= fyw[FRAC_BITS+15:FRAC_BITS];
    end
  end

  for (genvar k = 1; k <= 5; k++) begin : g_fdly
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        fx_q[k] <= fx_q[k-1];
        fy_q[k] <= fy_q[k-1];
      end
    end
  end

  assign x1 = x0_q + 32'd1;
  assign y1 = y0_q + 32'd1;

  ogn_fade u_fade_x (
    .clk_i (clk_i),
    .en_i  (en_i[4:1]),
    .t_i   (fx_q[0]),
    .s_o   (sx_f)
  );

  ogn_fade u_fade_y (
    .clk_i (clk_i),
    .en_i  (en_i[4:1]),
    .t_i   (fy_q[0]),
    .s_o   (sy_f)
  );

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      sx_q[5] <= sx_f;
      sy_q[5] <= sy_f;
    end
  end

  for (genvar k = 6; k <= 7; k++) begin : g_sxdly
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        sx_q[k] <= sx_q[k-1];
      end
    end
  end

  for (genvar k = 6; k <= 9; k++) begin : g_sydly
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        sy_q[k] <= sy_q[k-1];
      end
    end
  end

  // corners: bit 0 picks the right column, bit 1 the lower row
  for (genvar c = 0; c < 4; c++) begin : g_corner
    localparam bit XHI = (c % 2) == 1;
    localparam bit YHI = c >= 2;

    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic signed [33:0] px_q;
    logic signed [33:0] py_q;

    ogn_hash #(
      .ANGLE_BITS (ANGLE_BITS)
    ) u_hash (
      .clk_i  (clk_i),
      .en_i   (en_i[5:1]),
      .seed_i (seed_i),
      .cx_i   (XHI ? x1 : x0_q),
      .cy_i   (YHI ? y1 : y0_q),
      .gx_o   (gx),
      .gy_o   (gy)
    );

    assign dx = XHI ? $signed({2'b00, fx_q[5]}) - 18'sd65536 : $signed({2'b00, fx_q[5]});
    assign dy = YHI ? $signed({2'b00, fy_q[5]}) - 18'sd65536 : $signed({2'b00, fy_q[5]});

    always_ff @(posedge clk_i) begin
      if (en_i[6]) begin
        px_q <= dx * gx;
        py_q <= dy * gy;
      end
      if (en_i[7]) begin
        dot_q[c] <= DW'((35'(px_q) + 35'(py_q) + 35'sd8192) >>> 14);
      end
    end
  end

  // blend along x, then along y
  assign dtop   = DW1'(dot_q[1]) - DW1'(dot_q[0]);
  assign dbot   = DW1'(dot_q[3]) - DW1'(dot_q[2]);
  assign dy_mix = DW1'(bot_q) - DW1'(top_q);
  assign val    = DW'(top10_q + (my_q >>> 16));

  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      mtop_q <= $signed({1'b0, sx_q[7]}) * dtop;
      mbot_q <= $signed({1'b0, sx_q[7]}) * dbot;
      tl_q   <= dot_q[0];
      bl_q   <= dot_q[2];
    end
    if (en_i[9]) begin
      top_q <= DW'(tl_q + (mtop_q >>> 16));
      bot_q <= DW'(bl_q + (mbot_q >>> 16));
    end
    if (en_i[10]) begin
      my_q    <= $signed({1'b0, sy_q[9]}) * dy_mix;
      top10_q <= top_q;
    end
    if (en_i[11]) begin
      value_q <= val >>> LANE;
    end
  end

  assign value_o = value_q;

endmodule
